>>> src/ter_pkg.sv
package ter_pkg;

  localparam int CW        = 16;
  localparam int DIM_MAX   = 4096;
  localparam int DIM_W     = 13;
  localparam int PITCH_W   = 16;
  localparam int STRIDE_W  = PITCH_W - 2;
  localparam int PIX_W     = 12;
  localparam int ADDR_W    = 25;
  localparam int VAL_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // edge deltas, box offsets, products and edge values
  localparam int SW = CW + 1;
  localparam int OW = CW + 2;
  localparam int PW = SW + OW;
  localparam int EW = PW + 1;

  localparam int IN_TDATA_W   = 6 * CW + VAL_W;
  localparam int OUT_FIELDS_W = 2 * PIX_W + ADDR_W + VAL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_PITCH  = 2'd2,
    CFG_READY  = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [PITCH_W-1:0] pitch;
    logic               ready;
  } cfg_t;

  typedef struct packed {
    logic                 is_start;
    logic [2:0][CW-1:0]   vx;
    logic [2:0][CW-1:0]   vy;
    logic [VAL_W-1:0]     fill;
  } q_entry_t;

  typedef struct packed {
    logic [PIX_W-1:0]  px;
    logic [PIX_W-1:0]  py;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  value;
    logic              write;
    logic              last;
  } out_item_t;

endpackage

>>> src/triangle_edge_rasterizer_top.sv
// Edge-function triangle rasterizer. A start transaction (tuser 0) loads three vertices and a
// packed pixel value; its single result carries tlast 1 when nothing will be drawn. Each
// advance transaction (tuser 1) returns the next pixel of the clamped bounding box in
// row-major order with its word address and a coverage flag in out_tuser; tlast marks the
// final pixel, and an advance with no triangle in progress returns tlast 1 alone. Inputs
// pass through a two-entry queue into the execution unit, and results sit in an output
// register, so input is taken while a result waits. Advances run back to back while the
// output register can take a result; a start passes in the execution unit through vertex
// load, bounding box, edge multiplies, then edge setup together with the result, and waits
// in edge setup while the output register is still full. The multiply pipeline seeds the
// incremental edge values. The user must write surface registers through the cfg port only
// while no transaction is in flight; the block itself does not enforce this.
module triangle_edge_rasterizer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [ter_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ter_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y, fill_pixel
  input  logic [ter_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pixel_x, pixel_y, word_address, pixel_value, zero pad
  output logic [ter_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // write
  output logic                               out_tuser,
  output logic                               out_tlast
);

  ter_pkg::cfg_t      cfg_r;
  logic               q_valid;
  logic               q_pop;
  ter_pkg::q_entry_t  q_entry;
  ter_pkg::out_item_t out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= ter_pkg::DIM_W'(1024);
      cfg_r.height <= ter_pkg::DIM_W'(768);
      cfg_r.pitch  <= ter_pkg::PITCH_W'(4096);
      cfg_r.ready  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (ter_pkg::cfg_idx_t'(cfg_index))
        ter_pkg::CFG_WIDTH:  cfg_r.width  <= cfg_wdata[ter_pkg::DIM_W-1:0];
        ter_pkg::CFG_HEIGHT: cfg_r.height <= cfg_wdata[ter_pkg::DIM_W-1:0];
        ter_pkg::CFG_PITCH:  cfg_r.pitch  <= cfg_wdata[ter_pkg::PITCH_W-1:0];
        ter_pkg::CFG_READY:  cfg_r.ready  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ter_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_pop     (q_pop),
    .q_valid   (q_valid),
    .q_entry   (q_entry)
  );

  ter_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_item   (out_item)
  );

  assign out_tdata = {{(ter_pkg::OUT_TDATA_W - ter_pkg::OUT_FIELDS_W){1'b0}},
                      out_item.value, out_item.addr, out_item.py, out_item.px};
  assign out_tuser = out_item.write;
  assign out_tlast = out_item.last;

endmodule

>>> src/ter_front.sv
module ter_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ter_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tuser,
  input  logic                              q_pop,
  output logic                              q_valid,
  output ter_pkg::q_entry_t                 q_entry
);

  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  ter_pkg::q_entry_t mem_r [QDEPTH];
  logic [QPW-1:0]    wr_ptr_r;
  logic [QPW-1:0]    rd_ptr_r;
  logic [QCW-1:0]    cnt_r;
  ter_pkg::q_entry_t new_entry;
  logic              push;

  assign in_tready = (cnt_r != QCW'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != '0);
  assign q_entry   = mem_r[rd_ptr_r];

  // classify and unpack the incoming transaction
  always_comb begin
    new_entry.is_start = (ter_pkg::op_t'(in_tuser) == ter_pkg::OP_START);
    for (int i = 0; i < 3; i++) begin
      new_entry.vx[i] = in_tdata[2*i*ter_pkg::CW +: ter_pkg::CW];
      new_entry.vy[i] = in_tdata[(2*i+1)*ter_pkg::CW +: ter_pkg::CW];
    end
    new_entry.fill = in_tdata[6*ter_pkg::CW +: ter_pkg::VAL_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (q_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= new_entry;
  end

endmodule

>>> src/ter_back.sv
module ter_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ter_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  ter_pkg::q_entry_t  q_entry,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output ter_pkg::out_item_t out_item
);

  typedef enum logic [1:0] {ST_RUN, ST_BOX, ST_MUL, ST_FIN} state_t;
  typedef logic signed [ter_pkg::CW-1:0] coord_t;
  typedef logic signed [ter_pkg::SW-1:0] sx_t;
  typedef logic signed [ter_pkg::OW-1:0] ox_t;
  typedef logic signed [ter_pkg::PW-1:0] pw_t;
  typedef logic signed [ter_pkg::EW-1:0] ew_t;
  typedef logic [ter_pkg::PIX_W-1:0]     pix_t;

  // edge k runs from vertex IA[k] to vertex IB[k]
  localparam int IA [3] = '{1, 2, 0};
  localparam int IB [3] = '{2, 0, 1};

  state_t             state_r;
  logic               active_r;
  logic               out_valid_r;
  ter_pkg::out_item_t out_item_r;

  coord_t                    vx_r [3];
  coord_t                    vy_r [3];
  logic [ter_pkg::VAL_W-1:0] held_r;

  pix_t lo_x_r, hi_x_r, lo_y_r, hi_y_r;
  logic empty_r;
  sx_t  ea_r [3];
  sx_t  eb_r [3];
  ox_t  ox_r [3];
  ox_t  oy_r [3];
  pw_t  pa_r [3];
  pw_t  pb_r [3];
  pw_t  arp_r, arq_r;

  pix_t cx_r, cy_r;
  ew_t  wrow_r [3];
  ew_t  wcur_r [3];

  // box setup
  logic [ter_pkg::DIM_W-1:0] wcl, hcl;
  sx_t  mnx, mxx, mny, mxy, lim_x, lim_y, lo_x, hi_x, lo_y, hi_y;
  sx_t  ea [3];
  sx_t  eb [3];
  ox_t  ox [3];
  ox_t  oy [3];
  logic box_empty;

  // finish of setup
  ew_t  w_init [3];
  ew_t  area;
  logic fin_act;

  // traversal
  logic                                        out_free;
  logic                                        take;
  logic                                        emit;
  logic                                        all_ge, all_le, covered;
  logic                                        x_end, y_end;
  logic [ter_pkg::STRIDE_W-1:0]                stride;
  logic [ter_pkg::PIX_W+ter_pkg::STRIDE_W-1:0] yprod;
  ter_pkg::out_item_t                          adv_item;
  ter_pkg::out_item_t                          start_item;

  function automatic sx_t min3(input sx_t a, input sx_t b, input sx_t c);
    sx_t r;
    r = (a < b) ? a : b;
    return (r < c) ? r : c;
  endfunction

  function automatic sx_t max3(input sx_t a, input sx_t b, input sx_t c);
    sx_t r;
    r = (a > b) ? a : b;
    return (r > c) ? r : c;
  endfunction

  assign out_free   = !out_valid_r || out_tready;
  assign take       = (state_r == ST_RUN) && q_valid && out_free;
  assign q_pop      = take;
  assign emit       = (take && !q_entry.is_start) || ((state_r == ST_FIN) && out_free);
  assign out_tvalid = out_valid_r;
  assign out_item   = out_item_r;

  always_comb begin
    wcl = (cfg.width > ter_pkg::DIM_W'(ter_pkg::DIM_MAX)) ?
          ter_pkg::DIM_W'(ter_pkg::DIM_MAX) : cfg.width;
    hcl = (cfg.height > ter_pkg::DIM_W'(ter_pkg::DIM_MAX)) ?
          ter_pkg::DIM_W'(ter_pkg::DIM_MAX) : cfg.height;
    lim_x = sx_t'(wcl) - sx_t'(1);
    lim_y = sx_t'(hcl) - sx_t'(1);
    mnx = min3(sx_t'(vx_r[0]), sx_t'(vx_r[1]), sx_t'(vx_r[2]));
    mxx = max3(sx_t'(vx_r[0]), sx_t'(vx_r[1]), sx_t'(vx_r[2]));
    mny = min3(sx_t'(vy_r[0]), sx_t'(vy_r[1]), sx_t'(vy_r[2]));
    mxy = max3(sx_t'(vy_r[0]), sx_t'(vy_r[1]), sx_t'(vy_r[2]));
    lo_x = mnx[ter_pkg::SW-1] ? '0 : mnx;
    lo_y = mny[ter_pkg::SW-1] ? '0 : mny;
    hi_x = (mxx > lim_x) ? lim_x : mxx;
    hi_y = (mxy > lim_y) ? lim_y : mxy;
    box_empty = (lo_x > hi_x) || (lo_y > hi_y);
    for (int k = 0; k < 3; k++) begin
      ea[k] = sx_t'(vy_r[IB[k]]) - sx_t'(vy_r[IA[k]]);
      eb[k] = sx_t'(vx_r[IB[k]]) - sx_t'(vx_r[IA[k]]);
      ox[k] = ox_t'(lo_x) - ox_t'(vx_r[IA[k]]);
      oy[k] = ox_t'(lo_y) - ox_t'(vy_r[IA[k]]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w_init[k] = ew_t'(pa_r[k]) - ew_t'(pb_r[k]);
    end
    area    = ew_t'(arp_r) - ew_t'(arq_r);
    fin_act = cfg.ready && (area != '0) && !empty_r;

    start_item      = '0;
    start_item.last = !fin_act;
  end

  always_comb begin
    all_ge = 1'b1;
    all_le = 1'b1;
    for (int k = 0; k < 3; k++) begin
      all_ge = all_ge && !wcur_r[k][ter_pkg::EW-1];
      all_le = all_le && (wcur_r[k][ter_pkg::EW-1] || (wcur_r[k] == '0));
    end
    covered = all_ge || all_le;
    x_end   = (cx_r == hi_x_r);
    y_end   = (cy_r == hi_y_r);
    stride  = cfg.pitch[ter_pkg::PITCH_W-1:2];
    yprod   = (ter_pkg::PIX_W+ter_pkg::STRIDE_W)'(cy_r) *
              (ter_pkg::PIX_W+ter_pkg::STRIDE_W)'(stride);

    adv_item = '0;
    if (active_r) begin
      adv_item.px    = cx_r;
      adv_item.py    = cy_r;
      adv_item.addr  = yprod[ter_pkg::ADDR_W-1:0] + ter_pkg::ADDR_W'(cx_r);
      adv_item.value = held_r;
      adv_item.write = covered;
      adv_item.last  = x_end && y_end;
    end else begin
      adv_item.last  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_RUN: begin
          if (take) begin
            if (q_entry.is_start) begin
              state_r <= ST_BOX;
            end else if (active_r && x_end && y_end) begin
              active_r <= 1'b0;
            end
          end
        end
        ST_BOX: state_r <= ST_MUL;
        ST_MUL: state_r <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            active_r <= fin_act;
            state_r  <= ST_RUN;
          end
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_RUN: begin
        if (take) begin
          if (q_entry.is_start) begin
            for (int i = 0; i < 3; i++) begin
              vx_r[i] <= q_entry.vx[i];
              vy_r[i] <= q_entry.vy[i];
            end
            held_r <= q_entry.fill;
          end else begin
            out_item_r <= adv_item;
            if (active_r) begin
              if (x_end) begin
                if (!y_end) begin
                  cx_r <= lo_x_r;
                  cy_r <= cy_r + 1'b1;
                  for (int k = 0; k < 3; k++) begin
                    wrow_r[k] <= wrow_r[k] - ew_t'(eb_r[k]);
                    wcur_r[k] <= wrow_r[k] - ew_t'(eb_r[k]);
                  end
                end
              end else begin
                cx_r <= cx_r + 1'b1;
                for (int k = 0; k < 3; k++) begin
                  wcur_r[k] <= wcur_r[k] + ew_t'(ea_r[k]);
                end
              end
            end
          end
        end
      end
      ST_BOX: begin
        lo_x_r  <= lo_x[ter_pkg::PIX_W-1:0];
        hi_x_r  <= hi_x[ter_pkg::PIX_W-1:0];
        lo_y_r  <= lo_y[ter_pkg::PIX_W-1:0];
        hi_y_r  <= hi_y[ter_pkg::PIX_W-1:0];
        empty_r <= box_empty;
        for (int k = 0; k < 3; k++) begin
          ea_r[k] <= ea[k];
          eb_r[k] <= eb[k];
          ox_r[k] <= ox[k];
          oy_r[k] <= oy[k];
        end
      end
      ST_MUL: begin
        for (int k = 0; k < 3; k++) begin
          pa_r[k] <= pw_t'(ox_r[k]) * pw_t'(ea_r[k]);
          pb_r[k] <= pw_t'(oy_r[k]) * pw_t'(eb_r[k]);
        end
        arp_r <= pw_t'(ea_r[1]) * pw_t'(eb_r[2]);
        arq_r <= pw_t'(eb_r[1]) * pw_t'(ea_r[2]);
      end
      ST_FIN: begin
        if (out_free) begin
          out_item_r <= start_item;
          cx_r       <= lo_x_r;
          cy_r       <= lo_y_r;
          for (int k = 0; k < 3; k++) begin
            wrow_r[k] <= w_init[k];
            wcur_r[k] <= w_init[k];
          end
        end
      end
      default: ;
    endcase
  end

endmodule

>>> src/ter_checker.sv
module ter_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ter_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // queue space only shrinks on an input transaction
  a_ready_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !in_tvalid |=> in_tready)
    else $error("input ready dropped without a transaction");

endmodule

bind triangle_edge_rasterizer_top ter_checker u_ter_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
